[sv/wdms_pkg.sv]
`timescale 1ns / 1ps
package wdms_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int INIT_VERTICES = 4;
  localparam int IDX_W         = $clog2(MAX_VERTICES);
  localparam int CNT_W         = $clog2(MAX_VERTICES + 1);
  localparam int EDGE_DEPTH    = MAX_VERTICES * MAX_VERTICES;
  localparam int EDGE_AW       = 2 * IDX_W;
  localparam int LAB_W         = 16;

  localparam logic [2:0] REQ_ADD_V  = 3'd0;
  localparam logic [2:0] REQ_DEL_V  = 3'd1;
  localparam logic [2:0] REQ_ADD_E  = 3'd2;
  localparam logic [2:0] REQ_DEL_E  = 3'd3;
  localparam logic [2:0] REQ_QRY_E  = 3'd4;
  localparam logic [2:0] REQ_LIST   = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_MISSING = 3'd1;
  localparam logic [2:0] ST_LAB_EX  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EDGE_EX = 3'd4;
  localparam logic [2:0] ST_NO_EDGE = 3'd5;

  typedef enum logic [1:0] {
    EW_ZERO,
    EW_WEIGHT,
    EW_COPY
  } ew_sel_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_PLAIN,
    EMIT_QUERY,
    EMIT_MID,
    EMIT_LAST,
    EMIT_EMPTY
  } emit_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic signed [15:0] label_a;
    logic signed [15:0] label_b;
    logic signed [15:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         vertex_index;
    logic signed [15:0] neighbor_label;
    logic [5:0]         neighbor_index;
    logic signed [15:0] neighbor_weight;
    logic               no_neighbor;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               load_req;
    logic               lab_re;
    logic [IDX_W-1:0]   lab_raddr;
    logic               lab_we;
    logic [IDX_W-1:0]   lab_waddr;
    logic               lab_wcopy;
    logic               edge_re;
    logic [EDGE_AW-1:0] edge_raddr;
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_waddr;
    ew_sel_e            edge_wsel;
    emit_e              emit;
    logic [2:0]         st;
    logic [IDX_W-1:0]   vi;
    logic [IDX_W-1:0]   ni;
    logic               pend_load;
    logic               pend_clr;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       lab_eq_a;
    logic       lab_eq_b;
    logic       edge_nz;
    logic       pend_vld;
    logic       out_free;
  } dp_sts_t;

endpackage

[sv/wdms_ram.sv]
`timescale 1ns / 1ps
module wdms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/wdms_dp.sv]
`timescale 1ns / 1ps
module wdms_dp import wdms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  ctl_cmd_t  cmd_i,
  output dp_sts_t   sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  in_item_t         req_q;
  logic             lab_vld_q [MAX_VERTICES];
  logic [IDX_W-1:0] lab_ra_q;
  out_item_t        pend_q, pend_d, out_q, out_d;
  logic             pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;
  logic [LAB_W-1:0] lab_rd, lab_eff, lab_wdata;
  logic [15:0]      edge_rd, edge_wdata;
  logic             out_free;

  wdms_ram #(.WIDTH(LAB_W), .DEPTH(MAX_VERTICES)) u_lab_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.lab_we),
    .waddr_i (cmd_i.lab_waddr),
    .wdata_i (lab_wdata),
    .re_i    (cmd_i.lab_re),
    .raddr_i (cmd_i.lab_raddr),
    .rdata_o (lab_rd)
  );

  wdms_ram #(.WIDTH(16), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.edge_we),
    .waddr_i (cmd_i.edge_waddr),
    .wdata_i (edge_wdata),
    .re_i    (cmd_i.edge_re),
    .raddr_i (cmd_i.edge_raddr),
    .rdata_o (edge_rd)
  );

  assign lab_eff   = lab_vld_q[lab_ra_q] ? lab_rd : LAB_W'(lab_ra_q) + LAB_W'(1);
  assign lab_wdata = cmd_i.lab_wcopy ? lab_eff : $unsigned(req_q.label_a);
  assign out_free  = !out_vld_q || !out_stall_i;

  always_comb begin
    case (cmd_i.edge_wsel)
      EW_WEIGHT: edge_wdata = $unsigned(req_q.weight);
      EW_COPY:   edge_wdata = edge_rd;
      default:   edge_wdata = '0;
    endcase
  end

  always_comb begin
    sts_o.req      = req_q.req_type;
    sts_o.lab_eq_a = lab_eff == $unsigned(req_q.label_a);
    sts_o.lab_eq_b = lab_eff == $unsigned(req_q.label_b);
    sts_o.edge_nz  = edge_rd != '0;
    sts_o.pend_vld = pend_vld_q;
    sts_o.out_free = out_free;
  end

  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    if (cmd_i.pend_load) begin
      pend_d.status          = ST_OK;
      pend_d.vertex_index    = cmd_i.vi;
      pend_d.neighbor_label  = lab_eff;
      pend_d.neighbor_index  = cmd_i.ni;
      pend_d.neighbor_weight = edge_rd;
      pend_d.no_neighbor     = 1'b0;
      pend_d.last            = 1'b0;
      pend_vld_d             = 1'b1;
    end else if (cmd_i.pend_clr) begin
      pend_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (cmd_i.emit != EMIT_NONE) begin
      out_vld_d = 1'b1;
    end
    case (cmd_i.emit)
      EMIT_PLAIN, EMIT_QUERY, EMIT_EMPTY: begin
        out_d.status          = cmd_i.st;
        out_d.vertex_index    = cmd_i.vi;
        out_d.neighbor_label  = '0;
        out_d.neighbor_index  = '0;
        out_d.neighbor_weight = '0;
        out_d.no_neighbor     = cmd_i.emit == EMIT_EMPTY;
        out_d.last            = 1'b1;
        if (cmd_i.emit == EMIT_QUERY) begin
          out_d.neighbor_label  = req_q.label_b;
          out_d.neighbor_index  = cmd_i.ni;
          out_d.neighbor_weight = edge_rd;
        end
      end
      EMIT_MID: out_d = pend_q;
      EMIT_LAST: begin
        out_d      = pend_q;
        out_d.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int k = 0; k < MAX_VERTICES; k++) begin
        lab_vld_q[k] <= 1'b0;
      end
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cmd_i.lab_we) begin
        lab_vld_q[cmd_i.lab_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_item_i;
    end
    if (cmd_i.lab_re) begin
      lab_ra_q <= cmd_i.lab_raddr;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

[sv/wdms_ctrl.sv]
`timescale 1ns / 1ps
module wdms_ctrl import wdms_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_SA_RD  = 5'd2;
  localparam logic [4:0] S_SA_CMP = 5'd3;
  localparam logic [4:0] S_DSP_A  = 5'd4;
  localparam logic [4:0] S_SB_RD  = 5'd5;
  localparam logic [4:0] S_SB_CMP = 5'd6;
  localparam logic [4:0] S_DSP_B  = 5'd7;
  localparam logic [4:0] S_AV_LAB = 5'd8;
  localparam logic [4:0] S_AV_ROW = 5'd9;
  localparam logic [4:0] S_AV_COL = 5'd10;
  localparam logic [4:0] S_RV_RD  = 5'd11;
  localparam logic [4:0] S_RV_WR  = 5'd12;
  localparam logic [4:0] S_RM_RD  = 5'd13;
  localparam logic [4:0] S_RM_WR  = 5'd14;
  localparam logic [4:0] S_ED_CK  = 5'd15;
  localparam logic [4:0] S_SC_RD  = 5'd16;
  localparam logic [4:0] S_SC_CK  = 5'd17;
  localparam logic [4:0] S_SC_END = 5'd18;
  localparam logic [4:0] S_EMIT   = 5'd19;

  localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0]   INIT_CNT = CNT_W'(INIT_VERTICES);
  localparam logic [EDGE_AW-1:0] CLR_END  = EDGE_AW'(EDGE_DEPTH - 1);

  logic [4:0]         state_q, state_d;
  logic [EDGE_AW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic [IDX_W-1:0]   a_q, a_d, b_q, b_d, vi_q, vi_d;
  logic               a_fnd_q, a_fnd_d, b_fnd_q, b_fnd_d;
  logic [2:0]         st_q, st_d;
  emit_e              kind_q, kind_d;
  logic [CNT_W-1:0]   i_nx, j_nx, n_last;
  logic [IDX_W-1:0]   ii, jj, sr, sc;

  assign i_nx   = i_q + CNT_W'(1);
  assign j_nx   = j_q + CNT_W'(1);
  assign n_last = cnt_q - CNT_W'(1);
  assign ii     = i_q[IDX_W-1:0];
  assign jj     = j_q[IDX_W-1:0];
  assign sr     = ii + IDX_W'(ii >= a_q);
  assign sc     = jj + IDX_W'(jj >= a_q);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    a_d     = a_q;
    b_d     = b_q;
    a_fnd_d = a_fnd_q;
    b_fnd_d = b_fnd_q;
    st_d    = st_q;
    vi_d    = vi_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.edge_wsel = EW_ZERO;
    cmd_o.emit      = EMIT_NONE;
    in_stall_o = state_q != S_IDLE;

    unique case (state_q)
      S_CLR: begin
        cmd_o.edge_we    = 1'b1;
        cmd_o.edge_waddr = clr_q;
        clr_d = clr_q + EDGE_AW'(1);
        if (clr_q == CLR_END) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          i_d     = '0;
          a_d     = '0;
          b_d     = '0;
          a_fnd_d = 1'b0;
          b_fnd_d = 1'b0;
          state_d = S_SA_RD;
        end
      end
      S_SA_RD, S_SB_RD: begin
        if (i_q == cnt_q) begin
          state_d = (state_q == S_SA_RD) ? S_DSP_A : S_DSP_B;
        end else begin
          cmd_o.lab_re    = 1'b1;
          cmd_o.lab_raddr = ii;
          state_d = (state_q == S_SA_RD) ? S_SA_CMP : S_SB_CMP;
        end
      end
      S_SA_CMP: begin
        if (sts_i.lab_eq_a) begin
          a_d     = ii;
          a_fnd_d = 1'b1;
          state_d = S_DSP_A;
        end else begin
          i_d     = i_nx;
          state_d = S_SA_RD;
        end
      end
      S_SB_CMP: begin
        if (sts_i.lab_eq_b) begin
          b_d     = ii;
          b_fnd_d = 1'b1;
          state_d = S_DSP_B;
        end else begin
          i_d     = i_nx;
          state_d = S_SB_RD;
        end
      end
      S_DSP_A: begin
        kind_d = EMIT_PLAIN;
        vi_d   = '0;
        case (sts_i.req) inside
          REQ_ADD_V: begin
            if (cnt_q >= MAX_CNT) begin
              st_d    = ST_FULL;
              state_d = S_EMIT;
            end else if (a_fnd_q) begin
              st_d    = ST_LAB_EX;
              vi_d    = a_q;
              state_d = S_EMIT;
            end else begin
              state_d = S_AV_LAB;
            end
          end
          REQ_DEL_V: begin
            if (!a_fnd_q) begin
              st_d    = ST_MISSING;
              state_d = S_EMIT;
            end else begin
              i_d     = CNT_W'(a_q);
              state_d = S_RV_RD;
            end
          end
          REQ_ADD_E, REQ_DEL_E, REQ_QRY_E: begin
            i_d     = '0;
            state_d = S_SB_RD;
          end
          REQ_LIST: begin
            if (!a_fnd_q) begin
              st_d    = ST_MISSING;
              kind_d  = EMIT_EMPTY;
              state_d = S_EMIT;
            end else begin
              j_d     = '0;
              state_d = S_SC_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DSP_B: begin
        kind_d = EMIT_PLAIN;
        vi_d   = a_q;
        if (a_fnd_q && b_fnd_q) begin
          cmd_o.edge_re    = 1'b1;
          cmd_o.edge_raddr = {a_q, b_q};
          state_d = S_ED_CK;
        end else begin
          st_d    = (sts_i.req == REQ_ADD_E) ? ST_MISSING : ST_NO_EDGE;
          state_d = S_EMIT;
        end
      end
      S_ED_CK: begin
        state_d = S_EMIT;
        st_d    = ST_OK;
        cmd_o.edge_waddr = {a_q, b_q};
        case (sts_i.req)
          REQ_ADD_E: begin
            if (sts_i.edge_nz) begin
              st_d = ST_EDGE_EX;
            end else begin
              cmd_o.edge_we   = 1'b1;
              cmd_o.edge_wsel = EW_WEIGHT;
            end
          end
          REQ_DEL_E: begin
            if (!sts_i.edge_nz) begin
              st_d = ST_NO_EDGE;
            end else begin
              cmd_o.edge_we = 1'b1;
            end
          end
          default: begin
            if (!sts_i.edge_nz) begin
              st_d = ST_NO_EDGE;
            end else begin
              kind_d = EMIT_QUERY;
            end
          end
        endcase
      end
      S_AV_LAB: begin
        cmd_o.lab_we    = 1'b1;
        cmd_o.lab_waddr = cnt_q[IDX_W-1:0];
        i_d     = '0;
        state_d = S_AV_ROW;
      end
      S_AV_ROW: begin
        cmd_o.edge_we    = 1'b1;
        cmd_o.edge_waddr = {cnt_q[IDX_W-1:0], ii};
        state_d = S_AV_COL;
      end
      S_AV_COL: begin
        cmd_o.edge_we    = 1'b1;
        cmd_o.edge_waddr = {ii, cnt_q[IDX_W-1:0]};
        if (i_q == cnt_q) begin
          cnt_d   = cnt_q + CNT_W'(1);
          st_d    = ST_OK;
          vi_d    = cnt_q[IDX_W-1:0];
          state_d = S_EMIT;
        end else begin
          i_d     = i_nx;
          state_d = S_AV_ROW;
        end
      end
      S_RV_RD: begin
        if (i_q == n_last) begin
          i_d     = '0;
          j_d     = '0;
          state_d = S_RM_RD;
        end else begin
          cmd_o.lab_re    = 1'b1;
          cmd_o.lab_raddr = i_nx[IDX_W-1:0];
          state_d = S_RV_WR;
        end
      end
      S_RV_WR: begin
        cmd_o.lab_we    = 1'b1;
        cmd_o.lab_waddr = ii;
        cmd_o.lab_wcopy = 1'b1;
        i_d     = i_nx;
        state_d = S_RV_RD;
      end
      S_RM_RD: begin
        if (i_q == n_last) begin
          cnt_d   = n_last;
          st_d    = ST_OK;
          vi_d    = a_q;
          state_d = S_EMIT;
        end else begin
          cmd_o.edge_re    = 1'b1;
          cmd_o.edge_raddr = {sr, sc};
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.edge_we    = 1'b1;
        cmd_o.edge_waddr = {ii, jj};
        cmd_o.edge_wsel  = EW_COPY;
        if (j_q == n_last - CNT_W'(1)) begin
          j_d = '0;
          i_d = i_nx;
        end else begin
          j_d = j_nx;
        end
        state_d = S_RM_RD;
      end
      S_SC_RD: begin
        if (j_q == cnt_q) begin
          state_d = S_SC_END;
        end else begin
          cmd_o.edge_re    = 1'b1;
          cmd_o.edge_raddr = {a_q, jj};
          cmd_o.lab_re     = 1'b1;
          cmd_o.lab_raddr  = jj;
          state_d = S_SC_CK;
        end
      end
      S_SC_CK: begin
        if (!sts_i.edge_nz) begin
          j_d     = j_nx;
          state_d = S_SC_RD;
        end else if (!sts_i.pend_vld || sts_i.out_free) begin
          if (sts_i.pend_vld) begin
            cmd_o.emit = EMIT_MID;
          end
          cmd_o.pend_load = 1'b1;
          cmd_o.vi        = a_q;
          cmd_o.ni        = jj;
          j_d     = j_nx;
          state_d = S_SC_RD;
        end
      end
      S_SC_END: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = sts_i.pend_vld ? EMIT_LAST : EMIT_EMPTY;
          cmd_o.st       = ST_OK;
          cmd_o.vi       = a_q;
          cmd_o.pend_clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = kind_q;
          cmd_o.st   = st_q;
          cmd_o.vi   = vi_q;
          cmd_o.ni   = b_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= INIT_CNT;
      i_q     <= '0;
      j_q     <= '0;
      a_fnd_q <= 1'b0;
      b_fnd_q <= 1'b0;
      kind_q  <= EMIT_NONE;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      a_fnd_q <= a_fnd_d;
      b_fnd_q <= b_fnd_d;
      kind_q  <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    st_q <= st_d;
    vi_q <= vi_d;
  end

endmodule

[sv/weighted_digraph_matrix_store.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake                  | Payload
// in      | input     | in_valid_i / in_stall_o    | in_item_i  (in_item_t)
// out     | output    | out_valid_o / out_stall_i  | out_item_o (out_item_t)
//
// One item at a time; each label lookup visits the stored vertices in turn, a read and a compare for each.
// Edge requests and queries look up both labels; a neighbor list scans the row of the vertex.
// Remove vertex shifts the later labels down and then compacts the matrix
// through the edge memory, one read and one write per entry.
// After reset a clearing pass zeroes every edge memory entry; in_stall_o is high meanwhile.
// A stalled output holds the result and pauses the neighbor scan.
module weighted_digraph_matrix_store import wdms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  wdms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wdms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit != EMIT_NONE |-> sts.out_free)
    else $error("result issued while output register busy");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit != EMIT_NONE |=> out_valid_o)
    else $error("issued result not presented");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  a_mem_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.lab_we |-> !cmd.edge_we)
    else $error("label and edge writes in one cycle");

endmodule

[bench/weighted_digraph_matrix_store_test.sv]
`timescale 1ns / 1ps
module weighted_digraph_matrix_store_test;
  import wdms_pkg::*;

  class graph_scoreboard;
    int unsigned vcount;
    logic [15:0] labels [MAX_VERTICES];
    logic [15:0] weights [MAX_VERTICES][MAX_VERTICES];
    out_item_t   pending [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned list_results;

    function new();
      vcount = INIT_VERTICES;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        labels[i] = 16'(i + 1);
        for (int j = 0; j < MAX_VERTICES; j++) weights[i][j] = '0;
      end
      errors = 0;
      checked = 0;
      list_results = 0;
    endfunction

    function int find(logic [15:0] lab);
      for (int i = 0; i < vcount; i++)
        if (labels[i] == lab) return i;
      return -1;
    endfunction

    function void push(logic [2:0] st, int vi, logic [15:0] nl, int ni,
                       logic [15:0] nw, logic nn, logic lst);
      out_item_t o;
      o.status = st;
      o.vertex_index = 6'(vi);
      o.neighbor_label = nl;
      o.neighbor_index = 6'(ni);
      o.neighbor_weight = nw;
      o.no_neighbor = nn;
      o.last = lst;
      pending.push_back(o);
    endfunction

    function void note_request(in_item_t it);
      int a, b, va, n, k, sr, sc;
      logic [15:0] la, lb;
      la = it.label_a;
      lb = it.label_b;
      if (it.req_type > REQ_LIST) return;
      a = find(la);
      va = (a >= 0) ? a : 0;
      b = find(lb);
      case (it.req_type)
        REQ_ADD_V: begin
          if (vcount >= MAX_VERTICES) push(ST_FULL, 0, 0, 0, 0, 0, 1);
          else if (a >= 0) push(ST_LAB_EX, va, 0, 0, 0, 0, 1);
          else begin
            n = vcount;
            labels[n] = la;
            for (int i = 0; i <= n; i++) begin
              weights[n][i] = '0;
              weights[i][n] = '0;
            end
            vcount = n + 1;
            push(ST_OK, n, 0, 0, 0, 0, 1);
          end
        end
        REQ_DEL_V: begin
          if (a < 0) push(ST_MISSING, 0, 0, 0, 0, 0, 1);
          else begin
            n = vcount - 1;
            for (int i = va; i < n; i++) labels[i] = labels[i + 1];
            for (int r = 0; r < n; r++) begin
              sr = r + ((r >= va) ? 1 : 0);
              for (int c = 0; c < n; c++) begin
                sc = c + ((c >= va) ? 1 : 0);
                weights[r][c] = weights[sr][sc];
              end
            end
            vcount = n;
            push(ST_OK, va, 0, 0, 0, 0, 1);
          end
        end
        REQ_ADD_E: begin
          if (a < 0 || b < 0) push(ST_MISSING, va, 0, 0, 0, 0, 1);
          else if (weights[va][b] != 0) push(ST_EDGE_EX, va, 0, 0, 0, 0, 1);
          else begin
            weights[va][b] = it.weight;
            push(ST_OK, va, 0, 0, 0, 0, 1);
          end
        end
        REQ_DEL_E, REQ_QRY_E: begin
          if (a < 0 || b < 0 || weights[va][b] == 0) push(ST_NO_EDGE, va, 0, 0, 0, 0, 1);
          else if (it.req_type == REQ_DEL_E) begin
            weights[va][b] = '0;
            push(ST_OK, va, 0, 0, 0, 0, 1);
          end else push(ST_OK, va, lb, b, weights[va][b], 0, 1);
        end
        default: begin
          k = 0;
          if (a < 0) push(ST_MISSING, 0, 0, 0, 0, 1, 1);
          else begin
            for (int c = 0; c < vcount && k < 64; c++)
              if (weights[va][c] != 0) begin
                push(ST_OK, va, labels[c], c, weights[va][c], 0, 0);
                k++;
              end
            if (k == 0) push(ST_OK, va, 0, 0, 0, 1, 1);
            else pending[$].last = 1'b1;
            list_results += k;
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.vertex_index !== e.vertex_index) begin
        $error("vertex_index exp %0d got %0d", e.vertex_index, got.vertex_index); errors++;
      end
      if (got.neighbor_label !== e.neighbor_label) begin
        $error("neighbor_label exp %0d got %0d", e.neighbor_label, got.neighbor_label);
        errors++;
      end
      if (got.neighbor_index !== e.neighbor_index) begin
        $error("neighbor_index exp %0d got %0d", e.neighbor_index, got.neighbor_index);
        errors++;
      end
      if (got.neighbor_weight !== e.neighbor_weight) begin
        $error("neighbor_weight exp %0d got %0d", e.neighbor_weight, got.neighbor_weight);
        errors++;
      end
      if (got.no_neighbor !== e.no_neighbor) begin
        $error("no_neighbor exp %0d got %0d", e.no_neighbor, got.no_neighbor); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  graph_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     stall_mode;

  weighted_digraph_matrix_store dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: stall pattern switches between none, light, heavy and bursty
  initial begin
    out_stall_i = 1'b0;
    stall_mode = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ($urandom_range(0, 19) < 10) ? out_stall_i : ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);

  task automatic send(logic [2:0] rt, logic [15:0] la, logic [15:0] lb, logic [15:0] w);
    in_item_t it;
    it.req_type = rt;
    it.label_a = la;
    it.label_b = lb;
    it.weight = w;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(it);
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_label();
    if ($urandom_range(0, 4) != 0 && sb.vcount != 0)
      return sb.labels[$urandom_range(0, sb.vcount - 1)];
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 12));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0] rt;
    sb = new();
    burst_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(REQ_LIST, 16'd1, 16'd0, 16'd0);
    send(REQ_ADD_E, 16'd1, 16'd2, 16'h7fff);
    send(REQ_ADD_E, 16'd1, 16'd4, 16'h8000);
    send(REQ_ADD_E, 16'd1, 16'd2, 16'h0100);
    send(REQ_ADD_E, 16'd1, 16'd3, 16'h0000);
    send(REQ_ADD_E, 16'd9, 16'd3, 16'h0100);
    send(REQ_ADD_V, 16'h8000, 16'hffff, 16'hffff);
    send(REQ_ADD_V, 16'h7fff, 16'h0, 16'h0);
    send(REQ_ADD_V, 16'd2, 16'h0, 16'h0);
    send(REQ_ADD_E, 16'h8000, 16'h7fff, 16'hffff);
    send(REQ_LIST, 16'd1, 16'd0, 16'd0);
    send(REQ_QRY_E, 16'd1, 16'd4, 16'd0);
    send(REQ_QRY_E, 16'd1, 16'd3, 16'd0);
    send(REQ_QRY_E, 16'd77, 16'd4, 16'd0);
    send(REQ_DEL_E, 16'd1, 16'd2, 16'd0);
    send(REQ_DEL_E, 16'd1, 16'd2, 16'd0);
    send(REQ_DEL_V, 16'd2, 16'd0, 16'd0);
    send(REQ_DEL_V, 16'd2, 16'd0, 16'd0);
    send(REQ_LIST, 16'd1, 16'd0, 16'd0);
    send(REQ_LIST, 16'd55, 16'd0, 16'd0);
    send(3'd6, 16'd1, 16'd1, 16'd1);
    send(3'd7, 16'hffff, 16'hffff, 16'hffff);
    drain();

    // fill the store, hit the full case, wire a dense row, list it, delete a vertex and list again
    while (sb.vcount < MAX_VERTICES) send(REQ_ADD_V, 16'(100 + sb.vcount), 16'd0, 16'd0);
    send(REQ_ADD_V, 16'd5000, 16'd0, 16'd0);
    for (int i = 0; i < MAX_VERTICES; i++)
      send(REQ_ADD_E, sb.labels[0], sb.labels[i], 16'(i + 1));
    send(REQ_LIST, sb.labels[0], 16'd0, 16'd0);
    send(REQ_DEL_V, sb.labels[5], 16'd0, 16'd0);
    send(REQ_LIST, sb.labels[0], 16'd0, 16'd0);
    drain();

    for (int n = 0; n < 24; n++) begin
      rt = 3'($urandom_range(0, 99) < 3 ? $urandom_range(6, 7) : $urandom_range(0, 5));
      if (rt == REQ_ADD_V && sb.vcount > 20) rt = REQ_DEL_V;
      if (rt == REQ_ADD_V && $urandom_range(0, 1)) begin
        send(rt, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send(rt, pick_label(), pick_label(), pick_weight());
      end
      if (n == 12) drain();
    end
    drain();
    repeat (300) @(posedge clk_i);

    $display("checked %0d results, %0d of them neighbor list entries",
             sb.checked, sb.list_results);
    $display("final vertex count %0d", sb.vcount);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
